// ===== rtl/mts_pkg.sv =====
package mts_pkg;

  localparam int NUM_SLOTS_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 8;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_SLEEP = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_QUEUED = 2'd2
  } slot_st_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC_SCAN,
    S_DEQ_START,
    S_DEQ_WALK,
    S_DEQ_DONE,
    S_TOP,
    S_TICK_LOAD,
    S_ENQ_LINK,
    S_ENQ,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/multilevel_task_scheduler.sv =====
// Multilevel feedback-queue task scheduler. One command (allocate, run, sleep,
// tick) is taken per transaction while busy is low, and exactly one result is
// shown for one cycle with strobe high; the receiver cannot stall. After reset
// a clearing pass over every slot fills the slot tables while busy is high.
// A command keeps busy high from its accepting edge through its result cycle:
// run on a task already queued at that level goes from decode to the result;
// run on a task not queued decodes, links and enqueues it; run that moves a
// task first takes it off its old list by walking the links; allocate scans
// one slot per cycle; tick searches one level per cycle, then the head moves;
// sleep walks the list, then does the level search if the task was current. The next command
// can be accepted in the cycle after the result.
module multilevel_task_scheduler
  import mts_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       cmd,
  input  logic [5:0]       task_id,
  input  logic signed [3:0] target_level,
  input  logic [9:0]       new_priority,
  output logic             strobe,
  output logic [5:0]       result_task,
  output logic             alloc_ok,
  output logic             do_switch,
  output logic             reload_valid,
  output logic [9:0]       reload_ticks,
  output logic [2:0]       active_level
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_t state;

  // slot tables, one read and one write address per cycle
  slot_st_t        slot_status   [NUM_SLOTS];
  logic [LW-1:0]   slot_level    [NUM_SLOTS];
  logic [9:0]      slot_priority [NUM_SLOTS];
  logic [SW-1:0]   slot_next     [NUM_SLOTS];
  logic            slot_nv       [NUM_SLOTS];
  slot_st_t        rd_status;
  logic [LW-1:0]   rd_level;
  logic [9:0]      rd_prio;
  logic [SW-1:0]   rd_next;
  logic            rd_nv;
  logic [SW-1:0]   rd_addr;
  logic [SW-1:0]   wr_addr;
  logic            we_status, we_level, we_prio, we_link;
  slot_st_t        wd_status;
  logic [LW-1:0]   wd_level;
  logic [9:0]      wd_prio;
  logic [SW-1:0]   wd_next;
  logic            wd_nv;

  // level tables
  logic [SW-1:0]   level_head    [NUM_LEVELS];
  logic [SW-1:0]   level_tail    [NUM_LEVELS];
  logic [CW-1:0]   level_count   [NUM_LEVELS];
  logic [LW-1:0]   current_level;
  logic [SW-1:0]   current_task;

  // per-command registers
  cmd_t          c_cmd;
  logic [SW-1:0] c_tid;
  logic [3:0]    c_tlev;
  logic [9:0]    c_prio;
  logic [LW-1:0] c_lv;
  logic          c_was_cur;
  logic [LW-1:0] dl;
  logic [SW-1:0] t_next;
  logic          t_nv;
  logic [SW-1:0] cur;
  logic [CW-1:0] walk_i;
  logic [LW-1:0] scan_lv;
  logic [SW-1:0] scan_slot;
  logic [SW-1:0] clr_idx;
  logic          r_alloc, r_sw, r_rv;
  logic [9:0]    r_rt;

  // status toward the controller
  logic          tid_ok;
  logic [LW-1:0] tl_sat;
  logic [LW-1:0] run_lv;
  logic [LW-1:0] tick_lv;
  logic          clr_last, scan_hit, scan_last, run_move, run_enq, slot_queued;
  logic          deq_short, walk_end, walk_hit, top_hit, top_last;

  mts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .in_cmd      (cmd_t'(cmd)),
    .in_tid_ok   (tid_ok),
    .cur_cmd     (c_cmd),
    .clr_last    (clr_last),
    .scan_hit    (scan_hit),
    .scan_last   (scan_last),
    .run_move    (run_move),
    .run_enq     (run_enq),
    .slot_queued (slot_queued),
    .deq_short   (deq_short),
    .walk_end    (walk_end),
    .was_cur     (c_was_cur),
    .top_hit     (top_hit),
    .top_last    (top_last),
    .busy        (busy),
    .strobe      (strobe),
    .state       (state)
  );

  // input decode and status
  assign tid_ok      = ({26'd0, task_id} < 32'(NUM_SLOTS));
  assign tl_sat      = ({28'd0, c_tlev} < 32'(NUM_LEVELS)) ? LW'(c_tlev)
                                                           : LW'(NUM_LEVELS - 1);
  assign run_lv      = c_tlev[3] ? rd_level : tl_sat;
  assign tick_lv     = (dl > LW'(1)) ? dl - LW'(1) : dl;
  assign clr_last    = (clr_idx == SW'(NUM_SLOTS - 1));
  assign scan_hit    = (rd_status == ST_FREE);
  assign scan_last   = (scan_slot == SW'(NUM_SLOTS - 1));
  assign slot_queued = (rd_status == ST_QUEUED);
  assign run_move    = slot_queued && (rd_level != run_lv);
  assign run_enq     = !slot_queued;
  assign deq_short   = (level_count[dl] == '0) || (level_head[dl] == c_tid);
  assign walk_hit    = (walk_i < level_count[dl]) && rd_nv && (rd_next == c_tid);
  assign walk_end    = (walk_i >= level_count[dl]) || !rd_nv || (rd_next == c_tid);
  assign top_hit     = (level_count[scan_lv] != '0);
  assign top_last    = (scan_lv == '0);

  // slot table addresses and write data
  always_comb begin
    rd_addr   = c_tid;
    wr_addr   = c_tid;
    we_status = 1'b0;
    we_level  = 1'b0;
    we_prio   = 1'b0;
    we_link   = 1'b0;
    wd_status = ST_ALLOC;
    wd_level  = c_lv;
    wd_prio   = c_prio;
    wd_next   = '0;
    wd_nv     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_addr   = clr_idx;
        we_status = 1'b1;
        we_level  = 1'b1;
        we_prio   = 1'b1;
        we_link   = 1'b1;
        wd_status = (clr_idx == '0) ? ST_QUEUED : ST_FREE;
        wd_level  = '0;
        wd_prio   = (clr_idx == '0) ? 10'd2 : 10'd0;
      end
      S_IDLE: rd_addr = (cmd_t'(cmd) == CMD_ALLOC) ? '0 : SW'(task_id);
      S_DECODE: begin
        we_prio  = (c_cmd == CMD_RUN) && (c_prio != 10'd0);
        we_level = (c_cmd == CMD_RUN) && run_enq;
        wd_level = run_lv;
      end
      S_ALLOC_SCAN: begin
        wr_addr   = scan_slot;
        we_status = scan_hit;
        rd_addr   = scan_slot + SW'(1);
      end
      S_DEQ_START: rd_addr = level_head[dl];
      S_DEQ_WALK: begin
        rd_addr = rd_next;
        wr_addr = cur;
        we_link = walk_hit;
        wd_next = t_next;
        wd_nv   = t_nv;
      end
      S_DEQ_DONE: begin
        we_link   = 1'b1;
        we_status = 1'b1;
        we_level  = (c_cmd != CMD_SLEEP);
        wd_level  = (c_cmd == CMD_TICK) ? tick_lv : c_lv;
      end
      S_TOP: rd_addr = level_head[scan_lv];
      S_ENQ_LINK: begin
        wr_addr = level_tail[c_lv];
        we_link = (level_count[c_lv] != '0);
        wd_next = c_tid;
        wd_nv   = 1'b1;
      end
      S_ENQ: begin
        we_link   = 1'b1;
        we_status = 1'b1;
        wd_status = ST_QUEUED;
      end
      default: ;
    endcase
  end

  // slot tables with registered read
  always_ff @(posedge clk) begin
    if (we_status) slot_status[wr_addr] <= wd_status;
    if (we_level) slot_level[wr_addr] <= wd_level;
    if (we_prio) slot_priority[wr_addr] <= wd_prio;
    if (we_link) begin
      slot_next[wr_addr] <= wd_next;
      slot_nv[wr_addr]   <= wd_nv;
    end
    rd_status <= slot_status[rd_addr];
    rd_level  <= slot_level[rd_addr];
    rd_prio   <= slot_priority[rd_addr];
    rd_next   <= slot_next[rd_addr];
    rd_nv     <= slot_nv[rd_addr];
  end

  // level tables and command registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        level_head[l]  <= '0;
        level_tail[l]  <= '0;
        level_count[l] <= (l == 0) ? CW'(1) : '0;
      end
      current_level <= '0;
      current_task  <= '0;
      clr_idx       <= '0;
      c_cmd         <= CMD_ALLOC;
      r_alloc       <= 1'b0;
      r_sw          <= 1'b0;
      r_rv          <= 1'b0;
      r_rt          <= '0;
    end else begin
      unique case (state)
        S_CLEAR: clr_idx <= clr_idx + SW'(1);
        S_IDLE: begin
          if (start) begin
            c_cmd     <= cmd_t'(cmd);
            c_tid     <= SW'(task_id);
            c_tlev    <= target_level;
            c_prio    <= new_priority;
            r_alloc   <= 1'b0;
            r_sw      <= 1'b0;
            r_rv      <= 1'b0;
            r_rt      <= '0;
            scan_slot <= '0;
            scan_lv   <= LW'(NUM_LEVELS - 1);
          end
        end
        S_DECODE: begin
          dl        <= rd_level;
          t_next    <= rd_next;
          t_nv      <= rd_nv;
          c_lv      <= run_lv;
          c_was_cur <= (level_count[current_level] != '0) &&
                       (level_head[current_level] == c_tid);
        end
        // one slot per cycle
        S_ALLOC_SCAN: begin
          if (scan_hit) r_alloc <= 1'b1;
          else if (!scan_last) scan_slot <= scan_slot + SW'(1);
        end
        // remove c_tid from level dl
        S_DEQ_START: begin
          cur    <= level_head[dl];
          walk_i <= CW'(1);
          if (level_count[dl] != '0 && level_head[dl] == c_tid) begin
            if (level_count[dl] > CW'(1) && t_nv) level_head[dl] <= t_next;
            level_count[dl] <= level_count[dl] - CW'(1);
          end
        end
        // one link per cycle
        S_DEQ_WALK: begin
          if (walk_i >= level_count[dl] || !rd_nv) begin
            level_count[dl] <= level_count[dl] - CW'(1);
          end else if (rd_next == c_tid) begin
            if (level_tail[dl] == c_tid) level_tail[dl] <= cur;
            level_count[dl] <= level_count[dl] - CW'(1);
          end else begin
            cur    <= rd_next;
            walk_i <= walk_i + CW'(1);
          end
        end
        S_DEQ_DONE: begin
          if (c_cmd == CMD_TICK) c_lv <= tick_lv;
        end
        // highest nonempty level, one level per cycle
        S_TOP: begin
          if (top_hit) begin
            current_level <= scan_lv;
            current_task  <= level_head[scan_lv];
            if (c_cmd == CMD_SLEEP) begin
              r_sw <= 1'b1;
            end else begin
              c_tid <= level_head[scan_lv];
              r_rv  <= 1'b1;
              if (current_task != level_head[scan_lv]) r_sw <= 1'b1;
            end
          end else if (top_last) begin
            current_level <= '0;
          end else begin
            scan_lv <= scan_lv - LW'(1);
          end
        end
        // chosen head read back for its priority and links
        S_TICK_LOAD: begin
          r_rt   <= rd_prio;
          dl     <= rd_level;
          t_next <= rd_next;
          t_nv   <= rd_nv;
        end
        S_ENQ: begin
          if (level_count[c_lv] == '0) level_head[c_lv] <= c_tid;
          level_tail[c_lv] <= c_tid;
          if (level_count[c_lv] < CW'(NUM_SLOTS))
            level_count[c_lv] <= level_count[c_lv] + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // result ports
  assign result_task  = (c_cmd == CMD_ALLOC) ? (r_alloc ? 6'(scan_slot) : 6'd0)
                                             : 6'(current_task);
  assign alloc_ok     = r_alloc;
  assign do_switch    = r_sw;
  assign reload_valid = r_rv;
  assign reload_ticks = r_rt;
  assign active_level = 3'(current_level);

  // a result only shows up inside a command
  assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result outside a command");
  // reload only comes with a tick
  assert property (@(posedge clk) disable iff (rst)
                   (strobe && reload_valid) |-> (c_cmd == CMD_TICK))
    else $error("reload without tick");
  // allocate never reports a switch
  assert property (@(posedge clk) disable iff (rst)
                   (strobe && c_cmd == CMD_ALLOC) |-> !do_switch)
    else $error("switch on allocate");
  // only allocate claims a slot
  assert property (@(posedge clk) disable iff (rst)
                   (strobe && alloc_ok) |-> (c_cmd == CMD_ALLOC))
    else $error("claimed slot without allocate");

endmodule

// ===== rtl/mts_ctrl.sv =====
module mts_ctrl
  import mts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  cmd_t   in_cmd,
  input  logic   in_tid_ok,
  input  cmd_t   cur_cmd,
  input  logic   clr_last,
  input  logic   scan_hit,
  input  logic   scan_last,
  input  logic   run_move,
  input  logic   run_enq,
  input  logic   slot_queued,
  input  logic   deq_short,
  input  logic   walk_end,
  input  logic   was_cur,
  input  logic   top_hit,
  input  logic   top_last,
  output logic   busy,
  output logic   strobe,
  output state_t state
);

  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            CMD_ALLOC: state_next = S_ALLOC_SCAN;
            CMD_TICK:  state_next = S_TOP;
            default:   state_next = in_tid_ok ? S_DECODE : S_FINISH;
          endcase
        end
      end
      S_DECODE: begin
        unique case (cur_cmd)
          CMD_RUN: begin
            if (run_move) state_next = S_DEQ_START;
            else if (run_enq) state_next = S_ENQ_LINK;
            else state_next = S_FINISH;
          end
          CMD_SLEEP: state_next = slot_queued ? S_DEQ_START : S_FINISH;
          default:   state_next = S_FINISH;
        endcase
      end
      S_ALLOC_SCAN: if (scan_hit || scan_last) state_next = S_FINISH;
      S_DEQ_START:  state_next = deq_short ? S_DEQ_DONE : S_DEQ_WALK;
      S_DEQ_WALK:   if (walk_end) state_next = S_DEQ_DONE;
      S_DEQ_DONE: begin
        if (cur_cmd == CMD_SLEEP) state_next = was_cur ? S_TOP : S_FINISH;
        else state_next = S_ENQ_LINK;
      end
      S_TOP: begin
        if (top_hit) state_next = (cur_cmd == CMD_SLEEP) ? S_FINISH : S_TICK_LOAD;
        else if (top_last) state_next = S_FINISH;
      end
      S_TICK_LOAD: state_next = S_DEQ_START;
      S_ENQ_LINK:  state_next = S_ENQ;
      S_ENQ:       state_next = S_FINISH;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state != S_IDLE);
    strobe = (state == S_FINISH);
  end

  // result strobe lasts one cycle
  assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("strobe longer than one cycle");
  // an accepted transaction raises busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accept without busy");
  // result cycle always returns to idle
  assert property (@(posedge clk) disable iff (rst) (state == S_FINISH) |=> (state == S_IDLE))
    else $error("no return to idle");

endmodule
